FILE: sv/ptpi_pkg.sv
`timescale 1ns / 1ps

package ptpi_pkg;

   // angle / CORDIC datapath widths
   localparam int ANG_W    = 36;
   localparam int CX_W     = 34;
   localparam int TRIG_W   = 32;
   // shared multiplier
   localparam int OPD_W    = 33;
   localparam int PROD_W   = 66;
   localparam int MAC_SHIFT = 24;
   // divider
   localparam int DIV_QBITS = 46;
   localparam int DIV_DW    = 16;

   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [CX_W-1:0]   cx_type;
   typedef logic signed [TRIG_W-1:0] trig_type;
   typedef logic signed [OPD_W-1:0]  opd_type;
   typedef logic signed [PROD_W-1:0] acc_type;

   typedef struct packed {
      logic valid;
      logic clear;
      logic negate;
      logic shift;
   } mac_ctl_type;

   localparam ang_type Q30_ONE     = 36'sd1073741824;
   localparam ang_type Q30_PI      = 36'sd3373259426;
   localparam ang_type Q30_HALF_PI = 36'sd1686629713;
   localparam ang_type Q30_TWO_PI  = 36'sd6746518852;
   localparam ang_type Q30_GAIN    = 36'sd652032874;

   localparam logic signed [15:0] TRIG_ONE = 16'sd16384;

   function automatic ang_type atan_q30(input logic [4:0] idx);
      ang_type r;
      unique case (idx)
         5'd0:  r = 36'sd843314857;
         5'd1:  r = 36'sd497837829;
         5'd2:  r = 36'sd263043837;
         5'd3:  r = 36'sd133525159;
         5'd4:  r = 36'sd67021687;
         5'd5:  r = 36'sd33543516;
         5'd6:  r = 36'sd16775851;
         5'd7:  r = 36'sd8388437;
         5'd8:  r = 36'sd4194283;
         5'd9:  r = 36'sd2097149;
         5'd10: r = 36'sd1048576;
         5'd11: r = 36'sd524288;
         5'd12: r = 36'sd262144;
         5'd13: r = 36'sd131072;
         5'd14: r = 36'sd65536;
         5'd15: r = 36'sd32768;
         5'd16: r = 36'sd16384;
         5'd17: r = 36'sd8192;
         5'd18: r = 36'sd4096;
         5'd19: r = 36'sd2048;
         5'd20: r = 36'sd1024;
         5'd21: r = 36'sd512;
         5'd22: r = 36'sd256;
         5'd23: r = 36'sd128;
         5'd24: r = 36'sd64;
         5'd25: r = 36'sd32;
         5'd26: r = 36'sd16;
         5'd27: r = 36'sd8;
         5'd28: r = 36'sd4;
         5'd29: r = 36'sd2;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [15:0] trig_clamp(input logic signed [15:0] v);
      logic signed [15:0] r;
      if (v > TRIG_ONE) r = TRIG_ONE;
      else if (v < -TRIG_ONE) r = -TRIG_ONE;
      else r = v;
      return r;
   endfunction

endpackage

FILE: sv/planar_twist_pose_integrator.sv
`timescale 1ns / 1ps
// Channel   Handshake            Payload
// req       req_valid/req_ready  restart, angular_step, lin_x, lin_y
// rsp       rsp_valid/rsp_ready  out_x, out_y, out_cos, out_sin, straight_step, clipped
// csr       APB psel/penable     start_x, start_y, start_cos, start_sin, turn_threshold
//
// Straight step: twelve multiplies through the shared MAC.
// Turning step: the CORDIC, then the restoring divider's 46 iterations per
// position component, which take most of its time.
// req_ready is high only while the sequencer idles; one finished transaction can
// wait in the output register while the next is taken.
// Reset is synchronous, active high; no clearing pass.

module planar_twist_pose_integrator #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_restart,
   input  logic signed [15:0] req_angular_step,
   input  logic signed [31:0] req_lin_x,
   input  logic signed [31:0] req_lin_y,
   // response
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [15:0] rsp_out_cos,
   output logic signed [15:0] rsp_out_sin,
   output logic               rsp_straight_step,
   output logic               rsp_clipped,
   // configuration
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);
   import ptpi_pkg::*;

   // register map (word index)
   localparam logic [2:0] REG_START_X   = 3'd0;
   localparam logic [2:0] REG_START_Y   = 3'd1;
   localparam logic [2:0] REG_START_COS = 3'd2;
   localparam logic [2:0] REG_START_SIN = 3'd3;
   localparam logic [2:0] REG_THRESHOLD = 3'd4;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_TRIG  = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_DIVGO = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   // multiply-accumulate groups
   localparam logic [2:0] G_NUMX = 3'd0;
   localparam logic [2:0] G_NUMY = 3'd1;
   localparam logic [2:0] G_COS  = 3'd2;
   localparam logic [2:0] G_SIN  = 3'd3;
   localparam logic [2:0] G_POSX = 3'd4;
   localparam logic [2:0] G_POSY = 3'd5;

   localparam acc_type HEAD_RND = 66'sd536870912;   // half LSB at Q.30 -> Q.14
   localparam acc_type POS_RND  = 66'sd8192;        // half LSB at Q.14 shift
   localparam acc_type TRIG_MAX = 66'sd16384;
   localparam acc_type INT_MAX  = 66'sd2147483647;
   localparam acc_type INT_MIN  = -66'sd2147483648;

   // ---------------- configuration registers ----------------
   logic signed [31:0] start_x_ff, start_y_ff;
   logic signed [15:0] start_cos_ff, start_sin_ff;
   logic [11:0]        thr_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff   <= '0;
         start_y_ff   <= '0;
         start_cos_ff <= TRIG_ONE;
         start_sin_ff <= '0;
         thr_ff       <= 12'd1;
      end else if (csr_wr) begin
         unique case (csr_paddr[4:2])
            REG_START_X:   start_x_ff   <= csr_pwdata;
            REG_START_Y:   start_y_ff   <= csr_pwdata;
            REG_START_COS: start_cos_ff <= csr_pwdata[15:0];
            REG_START_SIN: start_sin_ff <= csr_pwdata[15:0];
            REG_THRESHOLD: thr_ff       <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_START_X:   csr_prdata = start_x_ff;
         REG_START_Y:   csr_prdata = start_y_ff;
         REG_START_COS: csr_prdata = {16'b0, start_cos_ff};
         REG_START_SIN: csr_prdata = {16'b0, start_sin_ff};
         REG_THRESHOLD: csr_prdata = {20'b0, thr_ff};
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- transaction state ----------------
   logic [2:0]         state_ff, group_ff, cnt_ff;
   logic               div_sel_ff;
   logic signed [31:0] pose_x_ff, pose_y_ff, dx_ff, dy_ff, nx_ff, ny_ff;
   logic signed [15:0] pose_c_ff, pose_s_ff, nc_ff, ns_ff;
   logic [DIV_DW-1:0]  w_mag_ff;
   logic               w_neg_ff, straight_ff, clip_ff;
   trig_type           c_ff, s_ff;
   logic signed [47:0] px_ff, py_ff;
   logic [63:0]        numx_mag_ff, numy_mag_ff;
   logic               numx_neg_ff, numy_neg_ff;

   logic               rsp_valid_ff, rsp_straight_ff, rsp_clip_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff;
   logic signed [15:0] rsp_c_ff, rsp_s_ff;

   logic               accept;
   logic signed [16:0] w_ext, w_abs;
   logic               straight_in;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign w_ext     = {req_angular_step[15], req_angular_step};
   assign w_abs     = w_ext[16] ? -w_ext : w_ext;
   assign straight_in = w_abs <= $signed({5'b0, thr_ff});

   // ---------------- CORDIC ----------------
   logic     trig_done;
   trig_type trig_c, trig_s;

   ptpi_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && !straight_in),
      .w       (req_angular_step),
      .done    (trig_done),
      .cos_out (trig_c),
      .sin_out (trig_s)
   );

   // ---------------- divider ----------------
   // round-half-away quotient: floor((|n| + |w|*2^17) / 2^18) / |w|
   logic [64:0]          div_sum;
   logic [DIV_QBITS-1:0] div_quo;
   logic                 div_done, q_neg;
   logic signed [47:0]   q_ext, q_signed;

   assign div_sum  = {1'b0, (div_sel_ff ? numy_mag_ff : numx_mag_ff)}
                     + {32'b0, w_mag_ff, 17'b0};
   assign q_neg    = (div_sel_ff ? numy_neg_ff : numx_neg_ff) ^ w_neg_ff;
   assign q_ext    = {2'b0, div_quo};
   assign q_signed = q_neg ? -q_ext : q_ext;

   ptpi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_DIVGO),
      .dividend (div_sum[63:18]),
      .divisor  (w_mag_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------- shared multiply-accumulate ----------------
   mac_ctl_type mac_ctl;
   opd_type     op_a, op_b, omc, pc33, ps33, dx33, dy33, s33, c33;
   opd_type     pxl, pxh, pyl, pyh;
   acc_type     acc;
   logic [2:0]  nops;

   assign omc  = opd_type'(Q30_ONE) - {c_ff[TRIG_W-1], c_ff};
   assign c33  = {c_ff[TRIG_W-1], c_ff};
   assign s33  = {s_ff[TRIG_W-1], s_ff};
   assign pc33 = {{17{pose_c_ff[15]}}, pose_c_ff};
   assign ps33 = {{17{pose_s_ff[15]}}, pose_s_ff};
   assign dx33 = {dx_ff[31], dx_ff};
   assign dy33 = {dy_ff[31], dy_ff};
   // 48 bit displacement taken in two halves
   assign pxl  = {9'b0, px_ff[23:0]};
   assign pxh  = {{9{px_ff[47]}}, px_ff[47:24]};
   assign pyl  = {9'b0, py_ff[23:0]};
   assign pyh  = {{9{py_ff[47]}}, py_ff[47:24]};
   assign nops = (group_ff == G_POSX || group_ff == G_POSY) ? 3'd4 : 3'd2;

   always_comb begin
      op_a = '0;
      op_b = '0;
      mac_ctl.valid  = (state_ff == S_MAC) && (cnt_ff < nops);
      mac_ctl.clear  = (cnt_ff == 3'd0);
      mac_ctl.negate = 1'b0;
      mac_ctl.shift  = cnt_ff[0];
      unique case (group_ff)
         G_NUMX: begin
            mac_ctl.shift  = 1'b0;
            mac_ctl.negate = cnt_ff[0];
            op_a = cnt_ff[0] ? omc : s33;
            op_b = cnt_ff[0] ? dy33 : dx33;
         end
         G_NUMY: begin
            mac_ctl.shift = 1'b0;
            op_a = cnt_ff[0] ? s33 : omc;
            op_b = cnt_ff[0] ? dy33 : dx33;
         end
         G_COS: begin
            mac_ctl.shift  = 1'b0;
            mac_ctl.negate = cnt_ff[0];
            op_a = cnt_ff[0] ? s33 : c33;
            op_b = cnt_ff[0] ? ps33 : pc33;
         end
         G_SIN: begin
            mac_ctl.shift = 1'b0;
            op_a = cnt_ff[0] ? s33 : c33;
            op_b = cnt_ff[0] ? pc33 : ps33;
         end
         G_POSX: begin
            mac_ctl.negate = cnt_ff[1];
            op_a = cnt_ff[1] ? (cnt_ff[0] ? pyh : pyl) : (cnt_ff[0] ? pxh : pxl);
            op_b = cnt_ff[1] ? ps33 : pc33;
         end
         G_POSY: begin
            op_a = cnt_ff[1] ? (cnt_ff[0] ? pyh : pyl) : (cnt_ff[0] ? pxh : pxl);
            op_b = cnt_ff[1] ? pc33 : ps33;
         end
         default: ;
      endcase
   end

   ptpi_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctl   (mac_ctl),
      .a     (op_a),
      .b     (op_b),
      .acc   (acc)
   );

   // ---------------- result shaping ----------------
   acc_type            acc_mag, head_q, pos_q, pos_sum;
   logic signed [15:0] head_in;
   logic signed [31:0] pos_in;
   logic               pos_clip;

   assign acc_mag = acc[PROD_W-1] ? -acc : acc;
   assign head_q  = (acc + HEAD_RND) >>> 30;
   assign pos_q   = (acc + POS_RND) >>> 14;
   assign pos_sum = pos_q + ((group_ff == G_POSX) ? acc_type'(pose_x_ff)
                                                  : acc_type'(pose_y_ff));

   always_comb begin
      if (head_q > TRIG_MAX) head_in = TRIG_ONE;
      else if (head_q < -TRIG_MAX) head_in = -TRIG_ONE;
      else head_in = head_q[15:0];
      pos_clip = 1'b1;
      if (pos_sum > INT_MAX) pos_in = 32'sh7fffffff;
      else if (pos_sum < INT_MIN) pos_in = 32'sh80000000;
      else begin
         pos_in   = pos_sum[31:0];
         pos_clip = 1'b0;
      end
   end

   // ---------------- sequencer ----------------
   logic out_free;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_c_ff    <= TRIG_ONE;
         pose_s_ff    <= '0;
      end else begin
         // S_DONE reloads the output register itself when it drains
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  dx_ff       <= req_lin_x;
                  dy_ff       <= req_lin_y;
                  w_mag_ff    <= w_abs[DIV_DW-1:0];
                  w_neg_ff    <= req_angular_step[15];
                  straight_ff <= straight_in;
                  clip_ff     <= 1'b0;
                  cnt_ff      <= '0;
                  if (req_restart) begin
                     pose_x_ff <= start_x_ff;
                     pose_y_ff <= start_y_ff;
                     pose_c_ff <= trig_clamp(start_cos_ff);
                     pose_s_ff <= trig_clamp(start_sin_ff);
                  end
                  if (straight_in) begin
                     // identity rotation, displacement taken as given
                     c_ff     <= trig_type'(Q30_ONE);
                     s_ff     <= '0;
                     px_ff    <= {{16{req_lin_x[31]}}, req_lin_x};
                     py_ff    <= {{16{req_lin_y[31]}}, req_lin_y};
                     group_ff <= G_COS;
                     state_ff <= S_MAC;
                  end else begin
                     state_ff <= S_TRIG;
                  end
               end
            end
            S_TRIG: begin
               if (trig_done) begin
                  c_ff     <= trig_c;
                  s_ff     <= trig_s;
                  group_ff <= G_NUMX;
                  state_ff <= S_MAC;
               end
            end
            S_MAC: begin
               if (cnt_ff == nops + 3'd1) begin
                  cnt_ff <= '0;
                  unique case (group_ff)
                     G_NUMX: begin
                        numx_mag_ff <= acc_mag[63:0];
                        numx_neg_ff <= acc[PROD_W-1];
                        group_ff    <= G_NUMY;
                     end
                     G_NUMY: begin
                        numy_mag_ff <= acc_mag[63:0];
                        numy_neg_ff <= acc[PROD_W-1];
                        div_sel_ff  <= 1'b0;
                        state_ff    <= S_DIVGO;
                     end
                     G_COS: begin
                        nc_ff    <= head_in;
                        group_ff <= G_SIN;
                     end
                     G_SIN: begin
                        ns_ff    <= head_in;
                        group_ff <= G_POSX;
                     end
                     G_POSX: begin
                        nx_ff    <= pos_in;
                        clip_ff  <= clip_ff | pos_clip;
                        group_ff <= G_POSY;
                     end
                     G_POSY: begin
                        ny_ff    <= pos_in;
                        clip_ff  <= clip_ff | pos_clip;
                        state_ff <= S_DONE;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end else begin
                  cnt_ff <= cnt_ff + 3'd1;
               end
            end
            S_DIVGO: state_ff <= S_DIV;
            S_DIV: begin
               if (div_done) begin
                  if (!div_sel_ff) begin
                     px_ff      <= q_signed;
                     div_sel_ff <= 1'b1;
                     state_ff   <= S_DIVGO;
                  end else begin
                     py_ff    <= q_signed;
                     group_ff <= G_COS;
                     state_ff <= S_MAC;
                  end
               end
            end
            S_DONE: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_x_ff        <= nx_ff;
                  rsp_y_ff        <= ny_ff;
                  rsp_c_ff        <= nc_ff;
                  rsp_s_ff        <= ns_ff;
                  rsp_straight_ff <= straight_ff;
                  rsp_clip_ff     <= clip_ff;
                  pose_x_ff       <= nx_ff;
                  pose_y_ff       <= ny_ff;
                  pose_c_ff       <= nc_ff;
                  pose_s_ff       <= ns_ff;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_x         = rsp_x_ff;
   assign rsp_out_y         = rsp_y_ff;
   assign rsp_out_cos       = rsp_c_ff;
   assign rsp_out_sin       = rsp_s_ff;
   assign rsp_straight_step = rsp_straight_ff;
   assign rsp_clipped       = rsp_clip_ff;

endmodule

FILE: sv/ptpi_cordic.sv
`timescale 1ns / 1ps

module ptpi_cordic #(
   parameter int STEPS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [15:0]             w,
   output logic                           done,
   output logic signed [ptpi_pkg::TRIG_W-1:0] cos_out,
   output logic signed [ptpi_pkg::TRIG_W-1:0] sin_out
);
   import ptpi_pkg::*;

   localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam logic [1:0] C_IDLE = 2'd0;
   localparam logic [1:0] C_FOLD = 2'd1;
   localparam logic [1:0] C_ITER = 2'd2;
   localparam logic [1:0] C_FIN  = 2'd3;

   logic [1:0]    state_ff;
   logic [IW-1:0] i_ff;
   ang_type       a_ff, a0;
   cx_type        x_ff, y_ff, tx, ty, xf, yf;
   ang_type       at;
   logic          flip_ff, done_ff;
   trig_type      cos_ff, sin_ff;

   localparam cx_type ONE_CX = cx_type'(Q30_ONE);

   // first range reduction by one turn is enough for a 16 bit Q3.12 angle
   always_comb begin
      a0 = {{2{w[15]}}, w, 18'b0};
      if (a0 > Q30_PI) a0 = a0 - Q30_TWO_PI;
      else if (a0 < -Q30_PI) a0 = a0 + Q30_TWO_PI;
   end

   assign tx = y_ff >>> i_ff;
   assign ty = x_ff >>> i_ff;
   assign at = atan_q30(5'(i_ff));
   assign xf = flip_ff ? -x_ff : x_ff;
   assign yf = flip_ff ? -y_ff : y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            C_IDLE: begin
               if (start) begin
                  a_ff     <= a0;
                  state_ff <= C_FOLD;
               end
            end
            C_FOLD: begin
               if (a_ff > Q30_HALF_PI) begin
                  a_ff    <= a_ff - Q30_PI;
                  flip_ff <= 1'b1;
               end else if (a_ff < -Q30_HALF_PI) begin
                  a_ff    <= a_ff + Q30_PI;
                  flip_ff <= 1'b1;
               end else begin
                  flip_ff <= 1'b0;
               end
               x_ff     <= cx_type'(Q30_GAIN);
               y_ff     <= '0;
               i_ff     <= '0;
               state_ff <= C_ITER;
            end
            C_ITER: begin
               if (a_ff >= 0) begin
                  x_ff <= x_ff - tx;
                  y_ff <= y_ff + ty;
                  a_ff <= a_ff - at;
               end else begin
                  x_ff <= x_ff + tx;
                  y_ff <= y_ff - ty;
                  a_ff <= a_ff + at;
               end
               if (i_ff == IW'(STEPS - 1)) state_ff <= C_FIN;
               else i_ff <= i_ff + 1'b1;
            end
            C_FIN: begin
               if (xf > ONE_CX) cos_ff <= trig_type'(ONE_CX);
               else if (xf < -ONE_CX) cos_ff <= trig_type'(-ONE_CX);
               else cos_ff <= xf[TRIG_W-1:0];
               if (yf > ONE_CX) sin_ff <= trig_type'(ONE_CX);
               else if (yf < -ONE_CX) sin_ff <= trig_type'(-ONE_CX);
               else sin_ff <= yf[TRIG_W-1:0];
               done_ff  <= 1'b1;
               state_ff <= C_IDLE;
            end
            default: state_ff <= C_IDLE;
         endcase
      end
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

FILE: sv/ptpi_divider.sv
`timescale 1ns / 1ps

module ptpi_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [ptpi_pkg::DIV_QBITS-1:0]     dividend,
   input  logic [ptpi_pkg::DIV_DW-1:0]        divisor,
   output logic                               done,
   output logic [ptpi_pkg::DIV_QBITS-1:0]     quotient
);
   import ptpi_pkg::*;

   localparam int CW = $clog2(DIV_QBITS + 1);

   logic [DIV_QBITS-1:0] dvd_ff;
   logic [DIV_DW-1:0]    dvs_ff, rem_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff, done_ff;
   logic [DIV_DW:0]      sh, diff;
   logic                 ge;

   // restoring division, one quotient bit per cycle
   assign sh   = {rem_ff, dvd_ff[DIV_QBITS-1]};
   assign ge   = sh >= {1'b0, dvs_ff};
   assign diff = sh - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= CW'(DIV_QBITS);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
            dvd_ff <= {dvd_ff[DIV_QBITS-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

FILE: sv/ptpi_mac.sv
`timescale 1ns / 1ps

module ptpi_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  ptpi_pkg::mac_ctl_type             ctl,
   input  logic signed [ptpi_pkg::OPD_W-1:0] a,
   input  logic signed [ptpi_pkg::OPD_W-1:0] b,
   output logic signed [ptpi_pkg::PROD_W-1:0] acc
);
   import ptpi_pkg::*;

   acc_type     prod_ff, acc_ff, term, shifted;
   mac_ctl_type ctl_ff;

   assign shifted = ctl_ff.shift ? (prod_ff <<< MAC_SHIFT) : prod_ff;
   assign term    = ctl_ff.negate ? -shifted : shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
      if (ctl_ff.valid) acc_ff <= (ctl_ff.clear ? acc_type'(0) : acc_ff) + term;
   end

   assign acc = acc_ff;

endmodule

FILE: sv/ptpi_checker.sv
`timescale 1ns / 1ps

module ptpi_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_out_x,
   input logic signed [31:0] rsp_out_y,
   input logic signed [15:0] rsp_out_cos,
   input logic signed [15:0] rsp_out_sin,
   input logic               rsp_clipped
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y))
      else $error("response changed while stalled");

   // the block is busy in the cycle after it takes a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after accept");

   // saturation flag must match a position at a rail
   a_clip: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_out_x == 32'sh7fffffff || rsp_out_x == 32'sh80000000 ||
         rsp_out_y == 32'sh7fffffff || rsp_out_y == 32'sh80000000)
      else $error("clipped without saturated position");

   // heading stays within unit range
   a_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_cos <= 16'sd16384 && rsp_out_cos >= -16'sd16384 &&
                    rsp_out_sin <= 16'sd16384 && rsp_out_sin >= -16'sd16384)
      else $error("heading out of range");

   // idle and empty right after reset
   a_reset: assert property (@(posedge clock) $fell(reset) |-> req_ready && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind planar_twist_pose_integrator ptpi_checker u_ptpi_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_out_x   (rsp_out_x),
   .rsp_out_y   (rsp_out_y),
   .rsp_out_cos (rsp_out_cos),
   .rsp_out_sin (rsp_out_sin),
   .rsp_clipped (rsp_clipped)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

// Pose integrator bench: APB config, random valid/ready pacing on both
// channels, and every response checked against typed-in values or a behavioral SE(2) model.
module tb;
   import ptpi_pkg::*;

   // CSR map, one 32-bit word per register
   typedef enum int {
      REG_START_X, REG_START_Y, REG_START_COS, REG_START_SIN, REG_TURN_THRESHOLD
   } csr_reg_e;

   localparam longint POS_MAX  = 64'sd2147483647;
   localparam longint POS_MIN  = -64'sd2147483648;
   localparam longint ONE_Q30  = 64'sd1073741824;
   localparam longint PI_Q30   = 64'sd3373259426;
   localparam longint HPI_Q30  = 64'sd1686629713;
   localparam longint TPI_Q30  = 64'sd6746518852;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint W_SCALE  = 64'sd262144;   // Q3.12 -> Q.30
   localparam int     CORDIC_ITERS = 16;

   // round(atan(2^-i) * 2^30)
   localparam longint ATAN_TAB [16] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
      65536, 32768
   };

   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [15:0] cos_h;
      logic signed [15:0] sin_h;
      logic               straight;
      logic               clip;
   } pose_result_t;

   typedef struct {
      bit                 restart;
      logic signed [15:0] w;
      logic signed [31:0] lx;
      logic signed [31:0] ly;
      bit                 checked;   // expected values typed in below
      pose_result_t       exp_res;
   } step_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_restart = 1'b0;
   logic signed [15:0] req_angular_step = '0;
   logic signed [31:0] req_lin_x = '0;
   logic signed [31:0] req_lin_y = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [15:0] rsp_out_cos;
   logic signed [15:0] rsp_out_sin;
   logic               rsp_straight_step;
   logic               rsp_clipped;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [4:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   // model copy of the registers and the pose
   logic [31:0] cfg_start_x = '0;
   logic [31:0] cfg_start_y = '0;
   logic [15:0] cfg_start_cos = 16'd16384;
   logic [15:0] cfg_start_sin = '0;
   logic [11:0] cfg_turn_thr = 12'd1;
   longint      pose_x = 0, pose_y = 0, pose_cos = 16384, pose_sin = 0;

   pose_result_t pending_poses[$];
   int           error_count = 0;
   int           send_idle_pct = 0;   // sender gap chance, percent
   int           stall_pct = 0;       // receiver stall chance, percent

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   planar_twist_pose_integrator i_dut (.*);

   // ---------------------------------------------------------------------
   // Behavioral model
   // ---------------------------------------------------------------------
   function automatic longint clamp_mag(input longint v, input longint lim);
      return (v > lim) ? lim : ((v < -lim) ? -lim : v);
   endfunction

   // add half, floor shift: ties round toward +inf
   function automatic longint round_shift(input longint v, input int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   // nearest, ties away from zero
   function automatic longint div_nearest(input longint n, input longint d);
      longint unsigned un, ud, q;
      un = (n < 0) ? -n : n;
      ud = (d < 0) ? -d : d;
      q = (un + ud / 2) / ud;
      return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint sat_pos(input longint v, inout bit clip);
      if (v > POS_MAX) begin
         clip = 1'b1;
         return POS_MAX;
      end
      if (v < POS_MIN) begin
         clip = 1'b1;
         return POS_MIN;
      end
      return v;
   endfunction

   // cos/sin of w in Q.30: wrap to [-pi,pi], fold to [-pi/2,pi/2], CORDIC
   function automatic void heading_trig(input longint w, output longint c,
                                        output longint s);
      longint a, x, y, tx, ty;
      bit     flip;
      a = w * W_SCALE;
      x = GAIN_Q30;
      y = 0;
      flip = 1'b0;
      while (a > PI_Q30) a -= TPI_Q30;
      while (a < -PI_Q30) a += TPI_Q30;
      if (a > HPI_Q30) begin
         a -= PI_Q30;
         flip = 1'b1;
      end else if (a < -HPI_Q30) begin
         a += PI_Q30;
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         tx = y >>> i;
         ty = x >>> i;
         if (a >= 0) begin
            x -= tx;
            y += ty;
            a -= ATAN_TAB[i];
         end else begin
            x += tx;
            y -= ty;
            a += ATAN_TAB[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clamp_mag(x, ONE_Q30);
      s = clamp_mag(y, ONE_Q30);
   endfunction

   function automatic pose_result_t integrate_twist(input bit restart,
         input logic signed [15:0] w16, input logic signed [31:0] lx,
         input logic signed [31:0] ly);
      pose_result_t r;
      longint w, dx, dy, c, s, px, py, omc, d, nc, ns, nx, ny;
      bit     straight, clip;
      w = w16;
      dx = lx;
      dy = ly;
      clip = 1'b0;
      if (restart) begin
         pose_x = longint'($signed(cfg_start_x));
         pose_y = longint'($signed(cfg_start_y));
         pose_cos = clamp_mag(longint'($signed(cfg_start_cos)), 16384);
         pose_sin = clamp_mag(longint'($signed(cfg_start_sin)), 16384);
      end
      straight = ((w < 0) ? -w : w) <= longint'(cfg_turn_thr);
      if (straight) begin
         c = ONE_Q30;
         s = 0;
         px = dx;
         py = dy;
      end else begin
         heading_trig(w, c, s);
         omc = ONE_Q30 - c;
         d = w * W_SCALE;
         px = div_nearest(s * dx - omc * dy, d);
         py = div_nearest(omc * dx + s * dy, d);
      end
      nc = clamp_mag(round_shift(pose_cos * c - pose_sin * s, 30), 16384);
      ns = clamp_mag(round_shift(pose_sin * c + pose_cos * s, 30), 16384);
      nx = sat_pos(pose_x + round_shift(pose_cos * px - pose_sin * py, 14), clip);
      ny = sat_pos(pose_y + round_shift(pose_sin * px + pose_cos * py, 14), clip);
      pose_x = nx;
      pose_y = ny;
      pose_cos = nc;
      pose_sin = ns;
      r.x = nx[31:0];
      r.y = ny[31:0];
      r.cos_h = nc[15:0];
      r.sin_h = ns[15:0];
      r.straight = straight;
      r.clip = clip;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stalls, compare against oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic check_field(input string name, input longint exp_v,
                              input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name,
                  exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      pose_result_t e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_poses.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual x=%0d y=%0d",
                     $realtime, rsp_out_x, rsp_out_y);
            error_count++;
         end else begin
            e = pending_poses.pop_front();
            check_field("out_x", e.x, rsp_out_x);
            check_field("out_y", e.y, rsp_out_y);
            check_field("out_cos", e.cos_h, rsp_out_cos);
            check_field("out_sin", e.sin_h, rsp_out_sin);
            check_field("straight_step", e.straight, rsp_straight_step);
            check_field("clipped", e.clip, rsp_clipped);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // setup + access phase; bits above the field width are junk on purpose
   task automatic csr_write(input csr_reg_e idx, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(idx * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         REG_START_X:        cfg_start_x = value;
         REG_START_Y:        cfg_start_y = value;
         REG_START_COS:      cfg_start_cos = value[15:0];
         REG_START_SIN:      cfg_start_sin = value[15:0];
         REG_TURN_THRESHOLD: cfg_turn_thr = value[11:0];
         default: ;
      endcase
   endtask

   // one request transaction; returns at the accepting edge
   task automatic send_step(input step_row_t row);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= row.restart;
      req_angular_step <= row.w;
      req_lin_x <= row.lx;
      req_lin_y <= row.ly;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (row.checked) begin
         void'(integrate_twist(row.restart, row.w, row.lx, row.ly));
         pending_poses.push_back(row.exp_res);
      end else begin
         pending_poses.push_back(integrate_twist(row.restart, row.w, row.lx, row.ly));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_poses.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic step_row_t random_step();
      step_row_t r;
      int        k;
      r.restart = ($urandom_range(9) == 0);
      k = $urandom_range(3);
      case (k)
         0: r.w = 16'($urandom_range(cfg_turn_thr + 2, cfg_turn_thr)
                      * ($urandom_range(1) ? 1 : -1));
         1: r.w = 16'($signed($urandom_range(2047)) - 1024);
         default: r.w = 16'($urandom);
      endcase
      if ($urandom_range(1)) begin
         r.lx = $urandom;
         r.ly = $urandom;
      end else begin
         r.lx = $signed($urandom_range(2097151)) - 1048576;
         r.ly = $signed($urandom_range(2097151)) - 1048576;
      end
      r.checked = 1'b0;
      r.exp_res = '{default: '0};
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Directed rows: reset pose, extremes, threshold edge, quadrant angles
   // ---------------------------------------------------------------------
   localparam logic signed [31:0] PMAX = 32'sh7fffffff;
   localparam logic signed [31:0] PMIN = 32'sh80000000;
   step_row_t directed_steps[] = '{
      '{1, 0, 0, 0, 1, '{0, 0, 16384, 0, 1, 0}},
      '{0, 0, PMAX, 0, 1, '{PMAX, 0, 16384, 0, 1, 0}},
      '{0, 0, PMAX, 0, 1, '{PMAX, 0, 16384, 0, 1, 1}},          // x saturates
      '{1, 0, PMIN, PMIN, 1, '{PMIN, PMIN, 16384, 0, 1, 0}},
      '{0, 0, PMIN, 0, 1, '{PMIN, PMIN, 16384, 0, 1, 1}},       // x saturates low
      '{1, 1, 65536, -65536, 1, '{65536, -65536, 16384, 0, 1, 0}}, // |w| at threshold
      '{1, -1, 0, 0, 1, '{0, 0, 16384, 0, 1, 0}},
      '{1, 2, 65536, 0, 0, '{default: '0}},                     // just turning
      '{0, -2, 0, 65536, 0, '{default: '0}},
      '{0, 16'sh7fff, PMAX, PMAX, 0, '{default: '0}},
      '{0, 16'sh8000, PMIN, PMIN, 0, '{default: '0}},
      '{1, 6434, 65536, 0, 0, '{default: '0}},                  // about pi/2
      '{0, 12868, 0, 65536, 0, '{default: '0}},                 // about pi
      '{0, -12868, 65536, 65536, 0, '{default: '0}},
      '{0, 25736, -65536, 0, 0, '{default: '0}},                // about 2 pi
      '{1, 4096, PMAX, PMIN, 0, '{default: '0}},
      '{0, -4096, 123456, -654321, 0, '{default: '0}}
   };

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_steps[i]) send_step(directed_steps[i]);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         // register settings per phase, the extremes among them
         case (phase)
            0: begin
               csr_write(REG_START_X, $urandom);
               csr_write(REG_START_Y, $urandom);
               csr_write(REG_TURN_THRESHOLD, 32'hfffff000 | 32'd200);
            end
            1: begin
               send_idle_pct = 69;
               stall_pct = 0;
               csr_write(REG_START_X, PMAX);
               csr_write(REG_START_Y, PMIN);
               csr_write(REG_START_COS, 32'habcd8000);  // out of range, clamps
               csr_write(REG_START_SIN, 32'h00007fff);
               csr_write(REG_TURN_THRESHOLD, 32'd0);
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 69;
               csr_write(REG_START_X, $urandom);
               csr_write(REG_START_Y, $urandom);
               csr_write(REG_START_COS, 32'($urandom_range(32768) - 16384));
               csr_write(REG_START_SIN, 32'($urandom_range(32768) - 16384));
               csr_write(REG_TURN_THRESHOLD, 32'd4095);
            end
            default: begin
               send_idle_pct = 37;
               stall_pct = 37;
               csr_write(REG_START_X, 32'd0);
               csr_write(REG_START_Y, 32'd0);
               csr_write(REG_START_COS, 32'd0);
               csr_write(REG_START_SIN, -32'sd16384);
               csr_write(REG_TURN_THRESHOLD, 32'($urandom_range(1, 64)));
            end
         endcase
         for (int n = 0; n < 250; n++) send_step(random_step());
         drain();
      end

      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #20000000;
      $display("FAIL");
      $finish;
   end

endmodule

FILE: planar_twist_pose_integrator.f
sv/ptpi_pkg.sv
sv/ptpi_cordic.sv
sv/ptpi_divider.sv
sv/ptpi_mac.sv
sv/planar_twist_pose_integrator.sv
sv/ptpi_checker.sv
tb/sv/tb.sv
